// File: hdl/mrq_pkg.sv
package mrq_pkg;

    // Storage geometry.
    localparam int SLOT_DEPTH   = 16;
    localparam int MESSAGE_BITS = 32;
    localparam int ADDR_BITS    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int COUNT_BITS   = $clog2(SLOT_DEPTH + 1);
    localparam int SUM_BITS     = COUNT_BITS + 1;

    // Field widths fixed by the interface.
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int WORD_BITS   = 32;
    localparam int OCC_BITS    = 5;
    localparam int CAP_BITS    = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_READY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY    = 2'd1;

    // Capacity after reset.
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Request actions.
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SEND = 2'd0,
        ACT_JAM  = 2'd1,
        ACT_RECV = 2'd2
    } action_t;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ERROR = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_WAIT  = 2'd2;

    // One request.
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [WORD_BITS-1:0]   message;
        logic                   wait_allowed;
    } request_t;

    // One result.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [WORD_BITS-1:0]   received;
        logic [OCC_BITS-1:0]    occupancy;
    } result_t;

    // Slot memory access issued by the controller.
    typedef struct packed {
        logic                    wr_en;
        logic [ADDR_BITS-1:0]    wr_addr;
        logic [MESSAGE_BITS-1:0] wr_data;
        logic                    rd_en;
        logic [ADDR_BITS-1:0]    rd_addr;
    } mem_cmd_t;

    // Outcome of a request, before registering.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [OCC_BITS-1:0]    occupancy;
        logic                   took;
    } outcome_t;

endpackage

// File: hdl/mrq_slot_ram.sv
module mrq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/mrq_ctrl.sv
module mrq_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  mrq_pkg::request_t                     request,
    input  logic                                  cfg_write,
    input  logic [mrq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mrq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output mrq_pkg::mem_cmd_t                     mem_cmd,
    output mrq_pkg::outcome_t                     outcome
);

    logic                               ready_reg;
    logic [mrq_pkg::CAP_BITS-1:0]       cap_reg;
    logic [mrq_pkg::ADDR_BITS-1:0]      head_reg;
    logic [mrq_pkg::ADDR_BITS-1:0]      head_next;
    logic [mrq_pkg::COUNT_BITS-1:0]     count_reg;
    logic [mrq_pkg::COUNT_BITS-1:0]     count_next;
    logic [mrq_pkg::COUNT_BITS-1:0]     eff_cap;
    logic [mrq_pkg::SUM_BITS-1:0]       tail_sum;
    logic [mrq_pkg::SUM_BITS-1:0]       head_inc;
    logic [mrq_pkg::ADDR_BITS-1:0]      tail_addr;
    logic [mrq_pkg::ADDR_BITS-1:0]      jam_addr;
    logic [mrq_pkg::ADDR_BITS-1:0]      recv_next;
    logic [mrq_pkg::STATUS_BITS-1:0]    fail_status;
    logic                               is_full;
    logic                               is_empty;

    // Effective capacity: zero acts as one, too large acts as the slot depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = mrq_pkg::COUNT_BITS'(1);
        end
        else if (int'(cap_reg) > mrq_pkg::SLOT_DEPTH)
        begin
            eff_cap = mrq_pkg::COUNT_BITS'(mrq_pkg::SLOT_DEPTH);
        end
        else
        begin
            eff_cap = mrq_pkg::COUNT_BITS'(cap_reg);
        end
    end

    // Ring index arithmetic, wrapped by compare against the capacity.
    always_comb
    begin
        tail_sum = mrq_pkg::SUM_BITS'(head_reg) + mrq_pkg::SUM_BITS'(count_reg);
        if (tail_sum >= mrq_pkg::SUM_BITS'(eff_cap))
        begin
            tail_sum = tail_sum - mrq_pkg::SUM_BITS'(eff_cap);
        end
        tail_addr = tail_sum[mrq_pkg::ADDR_BITS-1:0];

        if (head_reg == '0)
        begin
            jam_addr = mrq_pkg::ADDR_BITS'(eff_cap - mrq_pkg::COUNT_BITS'(1));
        end
        else
        begin
            jam_addr = head_reg - mrq_pkg::ADDR_BITS'(1);
        end

        head_inc = mrq_pkg::SUM_BITS'(head_reg) + mrq_pkg::SUM_BITS'(1);
        if (head_inc >= mrq_pkg::SUM_BITS'(eff_cap))
        begin
            recv_next = '0;
        end
        else
        begin
            recv_next = head_inc[mrq_pkg::ADDR_BITS-1:0];
        end
    end

    assign is_full     = (count_reg >= eff_cap);
    assign is_empty    = (count_reg == '0);
    assign fail_status = request.wait_allowed ? mrq_pkg::ST_WAIT : mrq_pkg::ST_ERROR;

    // Request decision and slot memory access.
    always_comb
    begin
        head_next         = head_reg;
        count_next        = count_reg;
        mem_cmd.wr_en     = 1'b0;
        mem_cmd.wr_addr   = tail_addr;
        mem_cmd.wr_data   = mrq_pkg::MESSAGE_BITS'(request.message);
        mem_cmd.rd_en     = 1'b0;
        mem_cmd.rd_addr   = head_reg;
        outcome.status    = mrq_pkg::ST_DONE;
        outcome.took      = 1'b0;

        priority if (!ready_reg)
        begin
            outcome.status = mrq_pkg::ST_ERROR;
        end
        else if (request.action == mrq_pkg::ACT_SEND || request.action == mrq_pkg::ACT_JAM)
        begin
            if (is_full)
            begin
                outcome.status = fail_status;
            end
            else
            begin
                mem_cmd.wr_en = accept;
                count_next    = count_reg + mrq_pkg::COUNT_BITS'(1);
                if (request.action == mrq_pkg::ACT_JAM)
                begin
                    mem_cmd.wr_addr = jam_addr;
                    head_next       = jam_addr;
                end
            end
        end
        else if (request.action == mrq_pkg::ACT_RECV)
        begin
            if (is_empty)
            begin
                outcome.status = fail_status;
            end
            else
            begin
                mem_cmd.rd_en = accept;
                outcome.took  = 1'b1;
                head_next     = recv_next;
                count_next    = count_reg - mrq_pkg::COUNT_BITS'(1);
            end
        end
        else
        begin
            // Unknown action code.
            outcome.status = mrq_pkg::ST_ERROR;
        end

        outcome.occupancy = mrq_pkg::OCC_BITS'(count_next);
    end

    // Configuration registers and ring pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            cap_reg   <= mrq_pkg::CAP_RESET;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == mrq_pkg::CFG_QUEUE_READY)
            begin
                ready_reg <= cfg_data[0];
            end
            else if (cfg_index == mrq_pkg::CFG_CAPACITY)
            begin
                cap_reg   <= mrq_pkg::CAP_BITS'(cfg_data);
                head_reg  <= '0;
                count_reg <= '0;
            end
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/message_ring_queue_core.sv
// Message ring queue with send, jam and receive requests.
// The result strobe rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, as the slot memory read for a
// receive completes in the cycle after the request and no later request can touch it.
// Reset clears the pointers and empties the queue, sets capacity to 16 and leaves the
// queue not ready; slot contents are undefined until written. The receiver cannot stall.
module message_ring_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mrq_pkg::request_t                 request,
    output logic                              done,
    output mrq_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mrq_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic                                accept;
    logic                                cfg_write;
    mrq_pkg::mem_cmd_t                   mem_cmd;
    mrq_pkg::outcome_t                   outcome;
    logic [mrq_pkg::MESSAGE_BITS-1:0]    rd_data;
    logic                                done_reg;
    logic                                took_reg;
    logic [mrq_pkg::STATUS_BITS-1:0]     status_reg;
    logic [mrq_pkg::OCC_BITS-1:0]        occ_reg;

    // Handshakes: the queue takes a request or a register write in any cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    mrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_cmd   (mem_cmd),
        .outcome   (outcome)
    );

    mrq_slot_ram #(
        .DEPTH (mrq_pkg::SLOT_DEPTH),
        .WIDTH (mrq_pkg::MESSAGE_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_data)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Result fields, aligned with the slot memory read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            took_reg   <= outcome.took;
            status_reg <= outcome.status;
            occ_reg    <= outcome.occupancy;
        end
    end

    assign done             = done_reg;
    assign result.status    = status_reg;
    assign result.occupancy = occ_reg;
    assign result.received  = took_reg ? mrq_pkg::WORD_BITS'(rd_data) : '0;

    // Every accepted request yields exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result after an accepted request");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a request");

    // Only a completed receive returns a message word.
    a_received_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != mrq_pkg::ST_DONE) |-> (result.received == '0))
        else $error("failed request returned a message");

    // Occupancy never exceeds the slot depth.
    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(result.occupancy) <= mrq_pkg::SLOT_DEPTH))
        else $error("occupancy above slot depth");

endmodule

// File: tb/sv/message_ring_queue_core_checker.sv
// Watches the request, result and register channels of the message queue,
// predicts every result and compares it with what the block returns.
module message_ring_queue_core_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  mrq_pkg::request_t                 request,
    input  logic                              done,
    input  mrq_pkg::result_t                  result,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mrq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mrq_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int unsigned                       fail_count,
    output int unsigned                       pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;

    // Predicted queue contents and settings.
    logic [MESSAGE_BITS-1:0] msg_store [SLOT_DEPTH];
    int                      head_slot;
    int                      held;
    logic                    queue_on;
    logic [CAP_BITS-1:0]     cap_setting;

    // Results predicted but not yet returned, oldest first.
    result_t awaited_results [$];

    assign pending_count = awaited_results.size();

    // Counts a failure and reports the first ten of them.
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] queue mismatch: %s", $realtime, what);
        end
    endtask

    // Applies one request to the predicted queue and returns its result.
    function automatic result_t apply_request(input request_t req);
        result_t                res;
        int                     cap;
        int                     tail;
        logic [STATUS_BITS-1:0] refusal;
        res = '0;
        res.status = ST_DONE;
        refusal = req.wait_allowed ? ST_WAIT : ST_ERROR;
        // A capacity of zero acts as one, anything above the depth as the depth.
        cap = (cap_setting == 0) ? 1 :
              (int'(cap_setting) > SLOT_DEPTH) ? SLOT_DEPTH : int'(cap_setting);
        if (!queue_on)
        begin
            res.status = ST_ERROR;
        end
        else
        begin
            case (req.action)
                ACT_SEND, ACT_JAM:
                begin
                    if (held >= cap)
                    begin
                        res.status = refusal;
                    end
                    else if (req.action == ACT_SEND)
                    begin
                        tail = head_slot + held;
                        if (tail >= cap)
                        begin
                            tail -= cap;
                        end
                        msg_store[tail] = req.message;
                        held++;
                    end
                    else
                    begin
                        head_slot = (head_slot == 0) ? cap - 1 : head_slot - 1;
                        msg_store[head_slot] = req.message;
                        held++;
                    end
                end
                ACT_RECV:
                begin
                    if (held == 0)
                    begin
                        res.status = refusal;
                    end
                    else
                    begin
                        res.received = msg_store[head_slot];
                        head_slot++;
                        if (head_slot >= cap)
                        begin
                            head_slot = 0;
                        end
                        held--;
                    end
                end
                // The unused action code is refused and changes nothing.
                default:
                begin
                    res.status = ST_ERROR;
                end
            endcase
        end
        res.occupancy = held[OCC_BITS-1:0];
        return res;
    endfunction

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            head_slot   = 0;
            held        = 0;
            queue_on    = 1'b0;
            cap_setting = CAP_RESET;
            awaited_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    note_failure($sformatf(
                        "result with nothing awaited: status %0d received %h occupancy %0d",
                        result.status, result.received, result.occupancy));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status ||
                        result.received !== want.received ||
                        result.occupancy !== want.occupancy)
                    begin
                        note_failure($sformatf(
                            "expected status %0d received %h occupancy %0d, %s %0d %h %0d",
                            want.status, want.received, want.occupancy, "got",
                            result.status, result.received, result.occupancy));
                    end
                end
            end
            // Register writes; a capacity write empties the queue.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_QUEUE_READY)
                begin
                    queue_on = cfg_data[0];
                end
                else if (cfg_index == CFG_CAPACITY)
                begin
                    cap_setting = cfg_data[CAP_BITS-1:0];
                    head_slot   = 0;
                    held        = 0;
                end
            end
            if (start && !busy)
            begin
                awaited_results.push_back(apply_request(request));
            end
        end
    end

    initial
    begin
        fail_count = 0;
    end

endmodule

// File: tb/sv/message_ring_queue_core_tb.sv
// Drives directed and random send, jam and receive requests into the queue,
// rewrites its registers between phases and reports the checker's verdict.
module message_ring_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;

    // The one action code that the package leaves unnamed.
    localparam logic [ACTION_BITS-1:0] ACT_UNKNOWN = 2'd3;
    // Register indexes beyond the list, whose writes are ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;
    localparam int                     CYCLE_LIMIT = 200000;
    localparam int                     SEGMENTS    = 12;
    localparam int                     SEG_ITEMS   = 42;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    request_t                 request;
    logic                     done;
    result_t                  result;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned accepted;
    int unsigned results_seen;
    int unsigned reg_writes;
    int unsigned action_tally [4];
    int unsigned cycles;
    int          idle_pct;

    message_ring_queue_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    message_ring_queue_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Returned results, counted so that register writes wait for an idle queue.
    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen <= results_seen + 1;
        end
    end

    // Guards against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("message_ring_queue_core regression: fail");
            $finish;
        end
    end

    // Presents one request after a random gap and holds it until taken.
    task automatic issue(input logic [ACTION_BITS-1:0] act,
                         input logic [WORD_BITS-1:0] msg, input logic may_wait);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start                <= 1'b1;
        request.action       <= act;
        request.message      <= msg;
        request.wait_allowed <= may_wait;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        accepted++;
        action_tally[act]++;
    endtask

    // Lets the queue go idle, then writes one register.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (results_seen != accepted)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Chooses an action, leaning towards filling, draining or neither.
    function automatic logic [ACTION_BITS-1:0] pick_action(input int lean);
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            return ACT_UNKNOWN;
        end
        case (lean)
            0:       return (r < 52) ? ACT_SEND : (r < 75) ? ACT_JAM : ACT_RECV;
            1:       return (r < 25) ? ACT_SEND : (r < 40) ? ACT_JAM : ACT_RECV;
            default: return (r < 40) ? ACT_SEND : (r < 58) ? ACT_JAM : ACT_RECV;
        endcase
    endfunction

    initial
    begin
        int cap_plan [SEGMENTS];
        int cap;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        accepted   = 0;
        results_seen = 0;
        reg_writes = 0;
        cycles     = 0;
        idle_pct   = 18;
        action_tally = '{default: 0};
        cap_plan   = '{16, 0, 31, 4, 1, 17, 16, -1, 2, 16, -1, 7};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Not set up yet: everything is refused, even when waiting is allowed.
        issue(ACT_SEND, 32'hFFFF_FFFF, 1'b1);
        issue(ACT_RECV, 32'h0, 1'b0);

        // A capacity of zero behaves as a single slot.
        write_register(CFG_QUEUE_READY, 5'b11111);
        write_register(CFG_CAPACITY, 5'd0);
        issue(ACT_SEND, 32'hFFFF_FFFF, 1'b0);
        issue(ACT_SEND, 32'h1234_5678, 1'b1);
        issue(ACT_JAM, 32'h0, 1'b0);
        issue(ACT_RECV, 32'h0, 1'b0);
        issue(ACT_RECV, 32'hFFFF_FFFF, 1'b1);
        issue(ACT_RECV, 32'h0, 1'b0);
        issue(ACT_JAM, 32'h0, 1'b1);
        issue(ACT_UNKNOWN, 32'hA5A5_5A5A, 1'b1);
        issue(ACT_RECV, 32'h0, 1'b0);

        // Ordering of sends and jams on a small ring, with wrap on both sides.
        write_register(CFG_SPARE_LOW, 5'd9);
        write_register(CFG_CAPACITY, 5'd3);
        issue(ACT_SEND, 32'h0000_00A1, 1'b0);
        issue(ACT_JAM, 32'h0000_00B2, 1'b0);
        issue(ACT_SEND, 32'h0000_00C3, 1'b1);
        issue(ACT_SEND, 32'h0000_00D4, 1'b0);
        issue(ACT_RECV, 32'h0, 1'b0);
        issue(ACT_RECV, 32'h0, 1'b0);
        issue(ACT_RECV, 32'h0, 1'b0);
        issue(ACT_RECV, 32'h0, 1'b1);

        // Random segments, each with its own capacity and a lean.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct = (seg < 4) ? 18 : (seg < 8) ? 84 : 0;
            cap = (cap_plan[seg] < 0) ? $urandom_range(16, 1) : cap_plan[seg];
            write_register(CFG_CAPACITY, cap[CFG_DATA_BITS-1:0]);
            if (seg == 2 || seg == 7)
            begin
                write_register(CFG_SPARE_HIGH, 5'($urandom()));
            end
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Mid-segment the queue is switched off and on, which keeps its contents.
                if ((seg == 3 || seg == 9) && n == SEG_ITEMS / 2)
                begin
                    write_register(CFG_QUEUE_READY, {4'($urandom()), 1'b0});
                end
                if ((seg == 3 || seg == 9) && n == SEG_ITEMS / 2 + 4)
                begin
                    write_register(CFG_QUEUE_READY, {4'($urandom()), 1'b1});
                end
                issue(pick_action((n < SEG_ITEMS / 2) ? seg % 3 : (seg + 1) % 3),
                      $urandom(), 1'($urandom_range(1)));
            end
        end

        // Drain and let the last result settle.
        @(negedge clk);
        start <= 1'b0;
        while (results_seen != accepted)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Ran %0d requests (%0d sends, %0d jams, %0d receives, %0d unknown)",
                 accepted, action_tally[ACT_SEND], action_tally[ACT_JAM],
                 action_tally[ACT_RECV], action_tally[ACT_UNKNOWN]);
        $display("through %0d register writes, capacities from 0 to 31, %0d failures.",
                 reg_writes, fail_count);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("message_ring_queue_core regression: pass");
        end
        else
        begin
            $display("message_ring_queue_core regression: fail");
        end
        $finish;
    end

endmodule
